[hdl/cet_pkg.sv]
// cet_pkg: shared types and constants of the 3x3 edge threshold block
// no dependencies; imported by every module under hdl but cet_ram
package cet_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 10;
  localparam int SUM_W = 10;   // three pixels summed, at most 765
  localparam int IDX_W = 2;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CFG_W-1:0] cfg_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [IDX_W-1:0] idx_t;

  // configuration register indexes
  localparam idx_t REG_THRESHOLD = 2'd0;
  localparam idx_t REG_WIDTH     = 2'd1;
  localparam idx_t REG_HEIGHT    = 2'd2;

  localparam cfg_t THRESHOLD_RST = 10'd40;
  localparam cfg_t WIDTH_RST     = 10'd512;
  localparam cfg_t HEIGHT_RST    = 10'd512;

  localparam pix_t WHITE = 8'd255;
  localparam pix_t BLACK = 8'd0;

  // per-word control carried from the position stage to the kernel stage
  typedef struct packed {
    pix_t pix;        // incoming pixel, zero on flush or drain rows
    logic first_col;  // window restarts at column zero
    logic up_ok;      // upper row store holds a frame row
    logic mid_ok;     // middle row store holds a frame row
    logic valid;      // this word completes a window inside the frame
    logic last;       // last result of the frame
  } item_t;

endpackage

[hdl/cet_ram.sv]
// cet_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module cet_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/cet_position.sv]
// cet_position: column and row counters, frame size clamping, per-word control
// depends on cet_pkg
module cet_position #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         accept,
  input  cet_pkg::pix_t                pixel_in,
  input  logic                         flush,
  input  cet_pkg::cfg_t                image_width,
  input  cet_pkg::cfg_t                image_height,
  output logic [$clog2(MAX_WIDTH)-1:0] addr,
  output cet_pkg::item_t               item
);
  import cet_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int YW = $clog2(MAX_HEIGHT + 2);

  logic [XW-1:0] col_count, col_count_next, x;
  logic [YW-1:0] row_count, row_count_next, y;
  logic [WW-1:0] w_lim;
  logic [YW-1:0] h_lim, h_end;
  logic          restart, last;

  always_comb begin
    if (image_width < CFG_W'(2)) begin
      w_lim = WW'(2);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(image_width);
    end
    if (image_height == '0) begin
      h_lim = YW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_lim = YW'(MAX_HEIGHT);
    end else begin
      h_lim = YW'(image_height);
    end
    h_end = h_lim + YW'(1);

    // stale position after a size change starts a fresh frame
    restart = (32'(col_count) >= 32'(w_lim)) || (row_count > h_end) ||
              ((row_count == h_end) && (col_count != '0));
    x = restart ? '0 : col_count;
    y = restart ? '0 : row_count;
    last = (x == '0) && (y == h_end);

    item.pix       = (flush || (y >= h_lim)) ? BLACK : pixel_in;
    item.first_col = (x == '0);
    item.up_ok     = (y >= YW'(2));
    item.mid_ok    = (y >= YW'(1));
    item.valid     = (x == '0) ? (y >= YW'(2)) : ((y >= YW'(1)) && (y <= h_lim));
    item.last      = last;

    if (last) begin
      col_count_next = '0;
      row_count_next = '0;
    end else if (32'(x) + 32'd1 >= 32'(w_lim)) begin
      col_count_next = '0;
      row_count_next = y + YW'(1);
    end else begin
      col_count_next = x + XW'(1);
      row_count_next = y;
    end
    addr = x;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      col_count <= col_count_next;
      row_count <= row_count_next;
    end
  end

endmodule

[hdl/cet_kernel.sv]
// cet_kernel: 3x3 window held as two column sums, gradient and threshold
// depends on cet_pkg
module cet_kernel (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  cet_pkg::item_t item,
  input  cet_pkg::pix_t  rd_upper,
  input  cet_pkg::pix_t  rd_middle,
  input  cet_pkg::cfg_t  threshold,
  output cet_pkg::pix_t  wr_upper,
  output cet_pkg::pix_t  wr_middle,
  output cet_pkg::pix_t  edge_pixel
);
  import cet_pkg::*;

  // only the two older window columns are kept, each as a sum of three rows
  sum_t sum_left, sum_right;
  pix_t up, mid;
  sum_t col_new, right, diff;

  always_comb begin
    up      = item.up_ok ? rd_upper : BLACK;
    mid     = item.mid_ok ? rd_middle : BLACK;
    col_new = SUM_W'(up) + SUM_W'(mid) + SUM_W'(item.pix);
    // at column zero the right neighbor lies outside the frame
    right   = item.first_col ? '0 : col_new;
    diff    = (sum_left >= right) ? (sum_left - right) : (right - sum_left);
    edge_pixel = (diff > threshold) ? WHITE : BLACK;
    wr_upper  = mid;
    wr_middle = item.pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_left  <= '0;
      sum_right <= '0;
    end else if (advance) begin
      sum_left  <= item.first_col ? '0 : sum_right;
      sum_right <= col_new;
    end
  end

endmodule

[hdl/conv3x3_edge_threshold_top.sv]
// conv3x3_edge_threshold_top: streaming 3x3 horizontal gradient edge detector
// depends on cet_pkg, cet_ram, cet_position, cet_kernel
//
//  channel  | signals                              | word
//  ---------+--------------------------------------+-----------------------
//  input    | in_valid, in_ready                   | pixel_in, flush
//  output   | out_valid, out_ready                 | edge_pixel, frame_end
//  config   | cfg_we, cfg_index                    | cfg_data
//
// one word per clock sustained while the output is not stalled; a result is loaded into
// the output register when the word completing its window moves on from the stage
// register, which takes the word and its row store read data at the accept edge.
// reset clears counters, window sums, the config registers and the valid flags; the row stores are not cleared.
// a stalled output holds its word while one more input word waits in the stage
// register, whose row store read data is held until it moves on.
module conv3x3_edge_threshold_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  cet_pkg::idx_t  cfg_index,
  input  cet_pkg::cfg_t  cfg_data,
  input  logic           in_valid,
  output logic           in_ready,
  input  cet_pkg::pix_t  pixel_in,
  input  logic           flush,
  output logic           out_valid,
  input  logic           out_ready,
  output cet_pkg::pix_t  edge_pixel,
  output logic           frame_end
);
  import cet_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);

  cfg_t edge_threshold, image_width, image_height;

  logic            accept, a_valid, a_adv;
  logic [XW-1:0]   pos_addr, a_addr;
  item_t           pos_item, a_item;
  logic [2*PIX_W-1:0] rd_word, wr_word;
  pix_t            wr_upper, wr_middle, kern_edge;

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_threshold <= THRESHOLD_RST;
      image_width    <= WIDTH_RST;
      image_height   <= HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THRESHOLD: edge_threshold <= cfg_data;
        REG_WIDTH:     image_width    <= cfg_data;
        REG_HEIGHT:    image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign a_adv    = a_valid && (!out_valid || out_ready);
  assign in_ready = !a_valid || a_adv;
  assign accept   = in_valid && in_ready;

  cet_position #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) u_position (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .pixel_in    (pixel_in),
    .flush       (flush),
    .image_width (image_width),
    .image_height(image_height),
    .addr        (pos_addr),
    .item        (pos_item)
  );

  // upper row in the high byte, middle row in the low byte
  cet_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_rows (
    .clk  (clk),
    .we   (a_adv),
    .waddr(a_addr),
    .wdata(wr_word),
    .re   (accept),
    .raddr(pos_addr),
    .rdata(rd_word)
  );

  assign wr_word = {wr_upper, wr_middle};

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_ready) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= pos_item;
      a_addr <= pos_addr;
    end
  end

  cet_kernel u_kernel (
    .clk       (clk),
    .rst       (rst),
    .advance   (a_adv),
    .item      (a_item),
    .rd_upper  (rd_word[2*PIX_W-1:PIX_W]),
    .rd_middle (rd_word[PIX_W-1:0]),
    .threshold (edge_threshold),
    .wr_upper  (wr_upper),
    .wr_middle (wr_middle),
    .edge_pixel(kern_edge)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (a_adv && a_item.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv && a_item.valid) begin
      edge_pixel <= kern_edge;
      frame_end  <= a_item.last;
    end
  end

`ifndef SYNTHESIS
  // row store data must survive while the stage waits on the output
  assert property (@(posedge clk) disable iff (rst)
    a_valid && !a_adv |=> $stable(rd_word))
    else $error("row store read data changed during stall");

  // the frame closes on a window that restarts at column zero
  assert property (@(posedge clk) disable iff (rst)
    a_valid && a_item.last |-> a_item.valid && a_item.first_col)
    else $error("frame end word without a valid result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (edge_pixel == WHITE) || (edge_pixel == BLACK))
    else $error("edge pixel is neither black nor white");

  // a result may only be loaded while the output register is free
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !a_adv)
    else $error("stage advanced over a waiting result");
`endif

endmodule

[dv/conv3x3_edge_threshold_top_tb.sv]
// testbench for conv3x3_edge_threshold_top: directed and random raster streams with flush words,
// a cycle-free model of the line stores and window, and a checker on the edge results
// depends on cet_pkg and the rtl under hdl
`timescale 1ns / 1ps

module conv3x3_edge_threshold_top_tb;
  import cet_pkg::*;

  localparam int   LINE_MAX    = 512;
  localparam int   SETTLE      = 10;    // cycles for the pipeline to drain before a write
  localparam int   STALL_LIMIT = 500;   // cycles with no handshake before giving up
  localparam int   RAND_WORDS  = 40;    // words of the randomized frames after the directed ones
  localparam idx_t REG_SPARE   = 2'd3;  // index with no register behind it

  typedef struct packed {
    pix_t pix;
    logic flush;
  } word_t;

  typedef struct packed {
    pix_t value;
    logic last;
  } edge_word_t;

  typedef enum int {TEX_NOISE, TEX_SOFT, TEX_BINARY} texture_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic cfg_we    = 1'b0;
  idx_t cfg_index = '0;
  cfg_t cfg_data  = '0;
  logic in_valid  = 1'b0;
  logic in_ready;
  pix_t pixel_in  = '0;
  logic flush     = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  pix_t edge_pixel;
  logic frame_end;

  conv3x3_edge_threshold_top dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .pixel_in(pixel_in),
    .flush(flush),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .edge_pixel(edge_pixel),
    .frame_end(frame_end)
  );

  always #6 clk = ~clk;

  word_t      word_q[$];   // words waiting to be driven
  edge_word_t edge_q[$];   // edge results still to arrive

  // model state
  cfg_t thr_r    = THRESHOLD_RST;
  cfg_t width_r  = WIDTH_RST;
  cfg_t height_r = HEIGHT_RST;
  pix_t upper_line[LINE_MAX];
  pix_t middle_line[LINE_MAX];
  pix_t win[9];            // column c, row r at c*3+r
  int   col_pos = 0;
  int   row_pos = 0;

  // raster position of the next word queued by the stimulus
  int gen_x = 0;
  int gen_y = 0;

  int errors      = 0;
  int words_in    = 0;
  int edges_seen  = 0;
  int frames_done = 0;
  int reg_writes  = 0;

  function automatic int eff_width();
    int w;
    w = int'(width_r);
    if (w < 2) w = 2;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = int'(height_r);
    if (h < 1) h = 1;
    if (h > LINE_MAX) h = LINE_MAX;
    return h;
  endfunction

  function automatic int win_col(int c);
    return int'(win[3*c]) + int'(win[3*c+1]) + int'(win[3*c+2]);
  endfunction

  // moves the window by one word and queues the edge result it completes
  task automatic advance_window(input pix_t p, input logic fl);
    int   w, h, x, y, lsum, rsum, diff;
    pix_t pv, up, mid;
    logic ok, last;
    w = eff_width();
    h = eff_height();
    x = col_pos;
    y = row_pos;
    if (x >= w || y > h + 1 || (y == h + 1 && x != 0)) begin
      x = 0;
      y = 0;
    end
    pv  = (fl || y >= h) ? BLACK : p;
    up  = (y >= 2) ? upper_line[x] : BLACK;
    mid = (y >= 1) ? middle_line[x] : BLACK;
    lsum = 0;
    rsum = 0;
    if (x == 0) begin
      // window of the last column of the row before: right column is padding
      lsum = win_col(1);
      ok = (y >= 2);
      for (int i = 0; i < 6; i++) win[i] = BLACK;
    end else begin
      for (int i = 0; i < 6; i++) win[i] = win[i+3];
      ok = (y >= 1 && y <= h);
    end
    win[6] = up;
    win[7] = mid;
    win[8] = pv;
    if (x != 0) begin
      lsum = win_col(0);
      rsum = win_col(2);
    end
    upper_line[x]  = mid;
    middle_line[x] = pv;
    last = (x == 0 && y == h + 1);
    if (last) begin
      x = 0;
      y = 0;
      frames_done++;
    end else begin
      x++;
      if (x >= w) begin
        x = 0;
        y++;
      end
    end
    col_pos = x;
    row_pos = y;
    if (ok) begin
      diff = (lsum >= rsum) ? lsum - rsum : rsum - lsum;
      edge_q.push_back('{(diff > int'(thr_r)) ? WHITE : BLACK, last});
    end
  endtask

  // driver
  word_t cur;
  int    gap_left = 0;
  logic  in_quiet = 1'b0;
  logic  next_valid;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        advance_window(cur.pix, cur.flush);
        words_in++;
        next_valid = 1'b0;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          next_valid = 1'b0;
        end else if (word_q.size() > 0) begin
          cur = word_q.pop_front();
          pixel_in <= cur.pix;
          flush <= cur.flush;
          next_valid = 1'b1;
          if ($urandom_range(0, 39) == 0) in_quiet = !in_quiet;
          gap_left = in_quiet ? 0 : $urandom_range(0, 5);
        end else begin
          next_valid = 1'b0;
        end
      end
      in_valid <= next_valid;
    end
  end

  // monitor
  int         stall_left = 0;
  logic       out_quiet  = 1'b0;
  edge_word_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (edge_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, edge_pixel=%0d frame_end=%0b",
                   $time, edge_pixel, frame_end);
        end else begin
          want = edge_q.pop_front();
          edges_seen++;
          if (edge_pixel !== want.value) begin
            errors++;
            $display("%0t: edge_pixel expected %0d actual %0d", $time, want.value, edge_pixel);
          end
          if (frame_end !== want.last) begin
            errors++;
            $display("%0t: frame_end expected %0b actual %0b", $time, want.last, frame_end);
          end
        end
        if ($urandom_range(0, 39) == 0) out_quiet = !out_quiet;
        stall_left = out_quiet ? 0 : $urandom_range(0, 5);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  // watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, STALL_LIMIT, edge_q.size());
      $display("FAIL conv3x3_edge_threshold_top");
      $finish;
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (word_q.size() != 0 || in_valid || edge_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input idx_t idx, input int v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= cfg_t'(v);
    case (idx)
      REG_THRESHOLD: thr_r = cfg_t'(v);
      REG_WIDTH:     width_r = cfg_t'(v);
      REG_HEIGHT:    height_r = cfg_t'(v);
      default: ;
    endcase
    reg_writes++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // takes the stream position from the model, restarted as the block would
  task automatic sync_gen();
    int w, h;
    w = eff_width();
    h = eff_height();
    gen_x = col_pos;
    gen_y = row_pos;
    if (gen_x >= w || gen_y > h + 1 || (gen_y == h + 1 && gen_x != 0)) begin
      gen_x = 0;
      gen_y = 0;
    end
  endtask

  function automatic int frame_left();
    int w, h;
    w = eff_width();
    h = eff_height();
    if (gen_y == h + 1) return 1;
    return (h + 1 - gen_y) * w - gen_x + 1;
  endfunction

  task automatic push_word(input pix_t p, input logic fl);
    int w, h;
    w = eff_width();
    h = eff_height();
    word_q.push_back('{p, fl});
    if (gen_x == 0 && gen_y == h + 1) begin
      gen_x = 0;
      gen_y = 0;
    end else begin
      gen_x++;
      if (gen_x >= w) begin
        gen_x = 0;
        gen_y++;
      end
    end
  endtask

  task automatic push_items(input int n, input texture_t tex);
    int   base;
    pix_t p;
    logic fl;
    base = $urandom_range(0, 231);
    @(negedge clk);
    repeat (n) begin
      case (tex)
        TEX_NOISE: p = pix_t'($urandom);
        TEX_SOFT:  p = pix_t'(base + $urandom_range(0, 24));
        default:   p = $urandom_range(0, 1) ? WHITE : BLACK;
      endcase
      // mostly real pixels inside the frame, mostly flush in the drain rows
      if (gen_y < eff_height()) fl = ($urandom_range(0, 19) == 0);
      else fl = ($urandom_range(0, 4) != 0);
      push_word(p, fl);
    end
  endtask

  int       rand_words;
  int       total;
  int       cut;
  int       rest;
  texture_t tex;

  initial begin
    for (int i = 0; i < 9; i++) win[i] = BLACK;
    for (int i = 0; i < LINE_MAX; i++) begin
      upper_line[i]  = BLACK;
      middle_line[i] = BLACK;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // 4x2 frame at the reset threshold, flush inside the frame, pixels in the drain rows
    write_reg(REG_WIDTH, 4);
    write_reg(REG_HEIGHT, 2);
    sync_gen();
    @(negedge clk);
    push_word(WHITE, 1'b0);
    push_word(BLACK, 1'b0);
    push_word(WHITE, 1'b0);
    push_word(BLACK, 1'b0);
    push_word(BLACK, 1'b0);
    push_word(WHITE, 1'b1);
    push_word(WHITE, 1'b0);
    push_word(WHITE, 1'b0);
    push_word(WHITE, 1'b0);
    push_word(WHITE, 1'b1);
    push_word(8'hAA, 1'b0);
    push_word(BLACK, 1'b1);
    push_word(WHITE, 1'b0);
    wait_idle();

    // zero threshold, width and height below range
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 0);
    sync_gen();
    @(negedge clk);
    push_word(8'd1, 1'b0);
    push_word(BLACK, 1'b0);
    push_word(WHITE, 1'b0);
    push_word(BLACK, 1'b1);
    push_word(8'h80, 1'b0);
    wait_idle();

    // threshold above any sum, plus a write to the unused index
    write_reg(REG_THRESHOLD, 1023);
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_SPARE, 1023);
    sync_gen();
    @(negedge clk);
    push_word(BLACK, 1'b0);
    push_word(WHITE, 1'b0);
    push_word(WHITE, 1'b0);
    push_word(WHITE, 1'b0);
    push_word(BLACK, 1'b1);
    push_word(WHITE, 1'b0);
    push_word(WHITE, 1'b1);
    wait_idle();

    // width above range clamps to the full line store: one row and the first
    // drain words, enough to see the column wrap at the store depth
    write_reg(REG_THRESHOLD, 200);
    write_reg(REG_WIDTH, 1023);
    sync_gen();
    push_items(LINE_MAX + 2, TEX_NOISE);
    wait_idle();

    // tall frame cut off by a smaller height, which restarts the position
    write_reg(REG_WIDTH, 3);
    write_reg(REG_HEIGHT, 1023);
    write_reg(REG_THRESHOLD, 30);
    sync_gen();
    push_items(10, TEX_SOFT);
    wait_idle();
    write_reg(REG_HEIGHT, 2);
    sync_gen();
    push_items(frame_left(), TEX_SOFT);

    rand_words = 0;
    while (rand_words < RAND_WORDS) begin
      if ($urandom_range(0, 2) == 0) begin
        wait_idle();
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 5))
            0:       write_reg(REG_THRESHOLD, 0);
            1:       write_reg(REG_THRESHOLD, 1023);
            2, 3:    write_reg(REG_THRESHOLD, $urandom_range(0, 250));
            default: write_reg(REG_THRESHOLD, $urandom_range(0, 1023));
          endcase
        end
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 7) == 0) write_reg(REG_WIDTH, $urandom_range(0, 1));
          else write_reg(REG_WIDTH, $urandom_range(2, 12));
        end
        if ($urandom_range(0, 1)) begin
          if ($urandom_range(0, 7) == 0) write_reg(REG_HEIGHT, 0);
          else write_reg(REG_HEIGHT, $urandom_range(1, 6));
        end
        sync_gen();
      end
      tex = texture_t'($urandom_range(0, 2));
      total = frame_left();
      if (total > 1 && $urandom_range(0, 4) == 0) begin
        // stop mid-frame until the block is empty, maybe change a register
        cut = $urandom_range(1, total - 1);
        push_items(cut, tex);
        wait_idle();
        case ($urandom_range(0, 3))
          0: write_reg(REG_THRESHOLD, $urandom_range(0, 300));
          1: write_reg(REG_HEIGHT, $urandom_range(0, 8));
          // only a row no wider than before keeps every store read on written entries
          2: write_reg(REG_WIDTH, $urandom_range(0, eff_width()));
          default: ;
        endcase
        sync_gen();
        rest = frame_left();
        push_items(rest, tex);
        rand_words += cut + rest;
      end else begin
        push_items(total, tex);
        rand_words += total;
      end
    end

    wait_idle();
    repeat (SETTLE) @(posedge clk);
    $display("run covered %0d pixel words and %0d edge results over %0d frames,",
             words_in, edges_seen, frames_done);
    $display("with %0d register writes, %0d mismatches", reg_writes, errors);
    if (errors == 0) begin
      $display("PASS conv3x3_edge_threshold_top");
    end else begin
      $display("FAIL conv3x3_edge_threshold_top");
    end
    $finish;
  end

endmodule
